### rtl/hhdl_pkg.sv
// Shared types, constants and defaults for the hash dictionary lookup.
package hhdl_pkg;

   localparam int FUNC_W = 2;
   localparam int ADDR_W = 16;
   localparam int DATA_W = 32;
   localparam int HASH_W = 27;
   localparam int WORD_W = 32;
   localparam int WIN_W  = 31;
   localparam int SUM_W  = 40;
   localparam int QDEPTH = 4;

   localparam int HASH_BITS_DEF   = 27;
   localparam int INDEX_BITS_DEF  = 9;
   localparam int TABLE_DEPTH_DEF = 65536;

   localparam logic [FUNC_W-1:0] FN_BUCKET = 2'd0;
   localparam logic [FUNC_W-1:0] FN_WORD   = 2'd1;
   localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

   typedef enum logic [1:0] {
      KIND_BUCKET,
      KIND_WORD,
      KIND_LOOKUP
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   addr;
      logic [DATA_W-1:0]   data;
      logic [HASH_W-1:0]   hash_value;
   } item_type;

   typedef struct packed {
      logic [4:0]        width;
      logic [WIN_W-1:0]  short_limit;
      logic [WIN_W-1:0]  long_limit;
      logic [WIN_W-1:0]  long_base;
      logic [WIN_W-1:0]  long_step;
   } cfg_type;

endpackage

### rtl/hhdl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hhdl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/hhdl_front.sv
// Front end: accepts items, drops ones with no effect, queues the rest.
module hhdl_front import hhdl_pkg::*; #(
   parameter int INDEX_BITS  = INDEX_BITS_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [ADDR_W-1:0] req_addr,
   input  logic [DATA_W-1:0] req_data,
   input  logic [HASH_W-1:0] req_hash_value,
   output logic              q_valid,
   output item_type          q_item,
   input  logic              q_take
);

   localparam int NUM_STARTS = (1 << INDEX_BITS) + 1;
   localparam int PW = $clog2(QDEPTH);

   item_type            q_ff [QDEPTH];
   logic [PW:0]         count_ff, count_in;
   logic [PW-1:0]       rd_ff, wr_ff;
   logic                accept, keep;
   item_type            item;

   assign full   = (count_ff == (PW+1)'(QDEPTH));
   assign accept = push && !full;

   always_comb begin
      item.addr       = req_addr;
      item.data       = req_data;
      item.hash_value = req_hash_value;
      item.kind       = KIND_LOOKUP;
      keep            = 1'b0;
      case (req_func)
         FN_BUCKET: begin
            item.kind = KIND_BUCKET;
            keep      = (32'(req_addr) < 32'(NUM_STARTS));
         end
         FN_WORD: begin
            item.kind = KIND_WORD;
            keep      = (32'(req_addr) < 32'(TABLE_DEPTH));
         end
         FN_LOOKUP: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (accept && keep) count_in = count_in + 1'b1;
      if (q_take)         count_in = count_in - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff    <= '0;
         wr_ff    <= '0;
      end else begin
         count_ff <= count_in;
         if (accept && keep) wr_ff <= wr_ff + 1'b1;
         if (q_take)         rd_ff <= rd_ff + 1'b1;
      end
      if (accept && keep) begin
         q_ff[wr_ff] <= item;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_item  = q_ff[rd_ff];

endmodule

### rtl/hhdl_back.sv
// Back end: executes queued loads and walks a bucket's gap codes per lookup.
module hhdl_back import hhdl_pkg::*; #(
   parameter int HASH_BITS   = HASH_BITS_DEF,
   parameter int INDEX_BITS  = INDEX_BITS_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_valid,
   input  item_type q_item,
   output logic     q_take,
   output logic     out_valid,
   output logic     out_found,
   input  logic     out_pop
);

   localparam int NUM_STARTS = (1 << INDEX_BITS) + 1;
   localparam int BS_AW = $clog2(NUM_STARTS);
   localparam int TW_AW = $clog2(TABLE_DEPTH);
   localparam int SH = (HASH_BITS > INDEX_BITS) ? (HASH_BITS - INDEX_BITS) : 0;
   localparam logic [31:0] HMASK = (32'h1 << HASH_BITS) - 32'h1;

   typedef enum logic [3:0] {
      S_IDLE, S_BS0, S_BS1, S_BS2, S_TW0, S_TW1, S_TW2, S_WIN,
      S_DEC, S_PRE, S_ADV, S_CHK, S_RES
   } state_type;

   state_type               state_ff;
   logic [HASH_W-1:0]       h_ff;
   logic [INDEX_BITS-1:0]   bkt_ff;
   logic [16:0]             wp_ff;
   logic [15:0]             tp_ff;
   logic [5:0]              bp_ff;
   logic [WORD_W-1:0]       w0_ff, w1_ff;
   logic [WIN_W-1:0]        y_ff;
   logic [SUM_W-1:0]        v_ff, gap_ff, sum_ff;
   logic [4:0]              k_ff;
   logic [5:0]              used_ff;
   logic                    out_valid_ff, found_ff, res_ff;

   logic                    bs_we, tw_we;
   logic [BS_AW-1:0]        bs_waddr, bs_raddr;
   logic [15:0]             bs_rdata;
   logic [TW_AW-1:0]        tw_waddr, tw_raddr;
   logic [WORD_W-1:0]       tw_rdata;
   logic [HASH_W-1:0]       h_in;
   logic [63:0]             pair;
   logic [WORD_W-1:0]       win;
   logic signed [7:0]       t;
   logic [5:0]              nbp;
   logic [16:0]             nwp, wp1;
   logic                    res_set;

   hhdl_ram #(.WIDTH(16), .DEPTH(NUM_STARTS)) u_bs (
      .clock(clock), .we(bs_we), .waddr(bs_waddr), .wdata(q_item.data[15:0]),
      .raddr(bs_raddr), .rdata(bs_rdata)
   );

   hhdl_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_tw (
      .clock(clock), .we(tw_we), .waddr(tw_waddr), .wdata(q_item.data),
      .raddr(tw_raddr), .rdata(tw_rdata)
   );

   assign q_take   = (state_ff == S_IDLE) && q_valid;
   assign bs_we    = q_take && (q_item.kind == KIND_BUCKET);
   assign tw_we    = q_take && (q_item.kind == KIND_WORD);
   assign bs_waddr = q_item.addr[BS_AW-1:0];
   assign tw_waddr = q_item.addr[TW_AW-1:0];
   assign h_in     = q_item.hash_value & HMASK[HASH_W-1:0];
   assign bs_raddr = (state_ff == S_BS1) ? BS_AW'({1'b0, bkt_ff} + 1'b1)
                                         : BS_AW'(bkt_ff);
   assign wp1      = wp_ff + 17'd1;
   assign tw_raddr = (state_ff == S_TW1) ? wp1[TW_AW-1:0] : wp_ff[TW_AW-1:0];
   assign pair     = {w0_ff, w1_ff};
   assign win      = WORD_W'(pair >> bp_ff);

   // bit position after consuming used_ff bits, with word carries
   always_comb begin
      t = $signed({2'b00, bp_ff}) - $signed({2'b00, used_ff});
      if (t > 8'sd0) begin
         nbp = t[5:0];
         nwp = wp_ff;
      end else if (t > -8'sd32) begin
         nbp = 6'(t + 8'sd32);
         nwp = wp_ff + 17'd1;
      end else begin
         nbp = 6'(t + 8'sd64);
         nwp = wp_ff + 17'd2;
      end
   end

   assign res_set = (state_ff == S_RES) && (!out_valid_ff || out_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (res_set) out_valid_ff <= 1'b1;
         else if (out_pop) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid && q_item.kind == KIND_LOOKUP) begin
                  h_ff     <= h_in;
                  bkt_ff   <= INDEX_BITS'({5'b0, h_in} >> SH);
                  state_ff <= S_BS0;
               end
            end
            S_BS0: state_ff <= S_BS1;
            S_BS1: begin
               wp_ff    <= {1'b0, bs_rdata};
               state_ff <= S_BS2;
            end
            S_BS2: begin
               tp_ff    <= bs_rdata;
               bp_ff    <= 6'd32;
               sum_ff   <= SUM_W'(bkt_ff) << SH;
               state_ff <= S_TW0;
            end
            S_TW0: state_ff <= S_TW1;
            S_TW1: begin
               w0_ff    <= (32'(wp_ff) < 32'(TABLE_DEPTH)) ? tw_rdata : '0;
               state_ff <= S_TW2;
            end
            S_TW2: begin
               w1_ff    <= (32'(wp1) < 32'(TABLE_DEPTH)) ? tw_rdata : '0;
               state_ff <= S_WIN;
            end
            S_WIN: begin
               y_ff     <= win[WORD_W-1:1];
               state_ff <= S_DEC;
            end
            S_DEC: begin
               if (y_ff < cfg.short_limit) begin
                  gap_ff   <= SUM_W'(y_ff >> (6'd32 - {1'b0, cfg.width}));
                  used_ff  <= {1'b0, cfg.width} - 6'd1;
                  state_ff <= S_ADV;
               end else begin
                  v_ff     <= SUM_W'(cfg.long_base);
                  k_ff     <= '0;
                  state_ff <= S_PRE;
               end
            end
            S_PRE: begin
               // take one prefix bit a cycle
               if (y_ff >= cfg.long_limit && k_ff != 5'd31) begin
                  y_ff <= {y_ff[WIN_W-2:0], 1'b0};
                  v_ff <= v_ff + SUM_W'(cfg.long_step);
                  k_ff <= k_ff + 5'd1;
               end else begin
                  gap_ff   <= v_ff + SUM_W'(y_ff >> (5'd31 - cfg.width));
                  used_ff  <= {1'b0, cfg.width} + {1'b0, k_ff};
                  state_ff <= S_ADV;
               end
            end
            S_ADV: begin
               if (used_ff == '0) begin
                  res_ff   <= 1'b0;
                  state_ff <= S_RES;
               end else if (nwp >= {1'b0, tp_ff} &&
                            (nwp > {1'b0, tp_ff} || nbp < 6'd32)) begin
                  res_ff   <= 1'b0;
                  state_ff <= S_RES;
               end else begin
                  bp_ff    <= nbp;
                  wp_ff    <= nwp;
                  sum_ff   <= sum_ff + gap_ff;
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               if (sum_ff < SUM_W'(h_ff)) begin
                  state_ff <= S_TW0;
               end else begin
                  res_ff   <= (sum_ff == SUM_W'(h_ff));
                  state_ff <= S_RES;
               end
            end
            S_RES: begin
               if (res_set) begin
                  found_ff <= res_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign out_valid = out_valid_ff;
   assign out_found = found_ff;

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_take |-> (state_ff == S_IDLE))
      else $error("item taken while a lookup is running");

   a_bp_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TW0) |-> (bp_ff != 6'd0 && bp_ff <= 6'd32))
      else $error("bit position out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_set |=> out_valid_ff && found_ff == $past(res_ff))
      else $error("result register lost a result");

endmodule

### rtl/huffman_hash_dictionary_lookup.sv
// Top level: configuration registers, front queue and lookup engine.
// Load items (bucket start or table word) pass through a four-entry queue
// and are written when the lookup engine is idle. A lookup fetches its
// bucket bounds, then for each gap code reads two table words through the
// table memory's single read port, decodes the code (one prefix bit at a
// time for a long code) and adds the gap to the running sum. One lookup
// runs at a time; found is held until popped while the next items still
// queue up. Reset leaves both memories undefined.
module huffman_hash_dictionary_lookup import hhdl_pkg::*; #(
   parameter int HASH_BITS   = HASH_BITS_DEF,
   parameter int INDEX_BITS  = INDEX_BITS_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [ADDR_W-1:0] req_addr,
   input  logic [DATA_W-1:0] req_data,
   input  logic [HASH_W-1:0] req_hash_value,
   output logic              empty,
   input  logic              pop,
   output logic              rsp_found,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam logic [2:0] REG_WIDTH = 3'd0;
   localparam logic [2:0] REG_SHORT = 3'd1;
   localparam logic [2:0] REG_LONG  = 3'd2;
   localparam logic [2:0] REG_BASE  = 3'd3;
   localparam logic [2:0] REG_STEP  = 3'd4;

   logic [4:0]       cw_ff;
   logic [WIN_W-1:0] scl_ff, lcl_ff, lcb_ff, lcs_ff;
   logic             wr;
   cfg_type          cfg;
   logic             q_valid, q_take, out_valid;
   item_type         q_item;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff  <= 5'd1;
         scl_ff <= '0;
         lcl_ff <= '0;
         lcb_ff <= '0;
         lcs_ff <= '0;
      end else if (wr) begin
         case (paddr[4:2])
            REG_WIDTH: cw_ff  <= pwdata[4:0];
            REG_SHORT: scl_ff <= pwdata[WIN_W-1:0];
            REG_LONG:  lcl_ff <= pwdata[WIN_W-1:0];
            REG_BASE:  lcb_ff <= pwdata[WIN_W-1:0];
            REG_STEP:  lcs_ff <= pwdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_WIDTH: prdata = {27'b0, cw_ff};
         REG_SHORT: prdata = {1'b0, scl_ff};
         REG_LONG:  prdata = {1'b0, lcl_ff};
         REG_BASE:  prdata = {1'b0, lcb_ff};
         REG_STEP:  prdata = {1'b0, lcs_ff};
         default:   prdata = '0;
      endcase
   end

   // zero width acts as one
   assign cfg.width       = (cw_ff == '0) ? 5'd1 : cw_ff;
   assign cfg.short_limit = scl_ff;
   assign cfg.long_limit  = lcl_ff;
   assign cfg.long_base   = lcb_ff;
   assign cfg.long_step   = lcs_ff;

   hhdl_front #(.INDEX_BITS(INDEX_BITS), .TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_func(req_func), .req_addr(req_addr), .req_data(req_data),
      .req_hash_value(req_hash_value),
      .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
   );

   hhdl_back #(.HASH_BITS(HASH_BITS), .INDEX_BITS(INDEX_BITS),
               .TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
      .out_valid(out_valid), .out_found(rsp_found), .out_pop(pop)
   );

   assign empty = !out_valid;

endmodule

### test/hhdl_csr_pkg.sv
// Register indexes and spare function code shared by the lookup testbench.
package hhdl_csr_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REG_CODE_WIDTH  = 0;
   localparam int REG_SHORT_LIMIT = 1;
   localparam int REG_LONG_LIMIT  = 2;
   localparam int REG_LONG_BASE   = 3;
   localparam int REG_LONG_STEP   = 4;

   localparam logic [1:0] FN_NONE = 2'd3;

endpackage

### test/hhdl_checker.sv
// Checker: mirrors the dictionary stores and registers, predicts found, compares.
module hhdl_checker import hhdl_pkg::*, hhdl_csr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              full,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [ADDR_W-1:0] req_addr,
   input  logic [DATA_W-1:0] req_data,
   input  logic [HASH_W-1:0] req_hash_value,
   input  logic              empty,
   input  logic              pop,
   input  logic              rsp_found,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output int                fail_count,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SHIFT   = HASH_BITS_DEF - INDEX_BITS_DEF;
   localparam int NSTARTS = (1 << INDEX_BITS_DEF) + 1;

   logic [15:0]  starts [0:NSTARTS-1];
   bit   [31:0]  words  [int];
   logic [4:0]   width_r;
   logic [30:0]  short_lim, long_lim, long_base, long_step;
   bit           found_q [$];

   function automatic bit [31:0] word_at(longint a);
      if (a < 0 || a >= TABLE_DEPTH_DEF || !words.exists(int'(a))) return 32'd0;
      return words[int'(a)];
   endfunction

   // Walk one bucket; stop_n > 0 halts after that many gaps, keeping the sum.
   function automatic bit walk(input logic [HASH_W-1:0] h, input int stop_n,
                               output longint unsigned last_sum);
      int unsigned bkt, w;
      longint wp, tp;
      int bp, used, k, n;
      longint unsigned sumv, gap, v;
      bit [31:0] w0, w1, win, y;
      bkt = h >> SHIFT;
      wp = starts[bkt];
      tp = starts[bkt+1];
      bp = 32;
      sumv = longint'(bkt) << SHIFT;
      w = width_r;
      if (w == 0) w = 1;
      n = 0;
      last_sum = sumv;
      while (1) begin
         w0 = word_at(wp);
         if (bp >= 32) win = w0;
         else begin
            w1 = word_at(wp + 1);
            win = (w0 << (32 - bp)) | (w1 >> bp);
         end
         y = win >> 1;
         if (y < {1'b0, short_lim}) begin
            gap = y >> (32 - w);
            used = w - 1;
         end else begin
            v = long_base;
            k = 0;
            while (y >= {1'b0, long_lim} && k < 31) begin
               y = (y << 1) & 32'h7FFF_FFFF;
               v += long_step;
               k++;
            end
            gap = v + (y >> (31 - w));
            used = w + k;
         end
         if (used == 0) return 0;
         bp -= used;
         while (bp <= 0) begin
            bp += 32;
            wp++;
         end
         if (wp >= tp && (wp > tp || bp < 32)) return 0;
         sumv += gap;
         n++;
         last_sum = sumv;
         if (n == stop_n) return 0;
         if (sumv >= h) return sumv == h;
      end
   endfunction

   task automatic report(string what, bit want, bit got);
      $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      longint unsigned dummy;
      if (reset) begin
         width_r   <= 5'd1;
         short_lim <= '0;
         long_lim  <= '0;
         long_base <= '0;
         long_step <= '0;
         found_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (int'(paddr >> 2))
               REG_CODE_WIDTH:  width_r   <= pwdata[4:0];
               REG_SHORT_LIMIT: short_lim <= pwdata[30:0];
               REG_LONG_LIMIT:  long_lim  <= pwdata[30:0];
               REG_LONG_BASE:   long_base <= pwdata[30:0];
               REG_LONG_STEP:   long_step <= pwdata[30:0];
               default: ;
            endcase
         end
         if (push && !full) begin
            case (req_func)
               FN_BUCKET: if (req_addr < NSTARTS) starts[req_addr] = req_data[15:0];
               FN_WORD:   words[int'(req_addr)] = req_data;
               FN_LOOKUP: found_q.push_back(walk(req_hash_value, 0, dummy));
               default: ;
            endcase
         end
         if (pop && !empty) begin
            if (found_q.size() == 0) begin
               $display("%0t unexpected result found=%0d", $realtime, rsp_found);
               fail_count++;
            end else if (found_q.pop_front() != rsp_found)
               report("found", !rsp_found, rsp_found);
         end
      end
      pending <= found_q.size();
   end

   final begin
   end
endmodule

### test/tb_top.sv
// Top: clock, reset, stimulus, idling and verdict for the dictionary lookup.
module tb_top import hhdl_pkg::*, hhdl_csr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 40000;
   localparam int HOLD_CYCLES = 300;

   logic              clock, reset;
   logic              push, full, empty, pop, rsp_found;
   logic [FUNC_W-1:0] req_func;
   logic [ADDR_W-1:0] req_addr;
   logic [DATA_W-1:0] req_data;
   logic [HASH_W-1:0] req_hash_value;
   logic              psel, penable, pwrite, pready;
   logic [4:0]        paddr;
   logic [31:0]       pwdata, prdata;
   int                fail_count, pending;
   int                tx_idle, rx_idle, quiet;
   bit                hold_req;

   huffman_hash_dictionary_lookup i_dut (.*);

   hhdl_checker i_chk (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Receiver: random pops, with one long hold-off on request.
   initial begin
      pop = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 0;
            pop <= 0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else
            pop <= ($urandom_range(99) >= rx_idle);
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || reset) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic send(logic [1:0] f, logic [15:0] a, logic [31:0] d, logic [26:0] h);
      while ($urandom_range(99) < tx_idle) begin
         push <= 0;
         @(negedge clock);
      end
      push <= 1;
      req_func <= f;
      req_addr <= a;
      req_data <= d;
      req_hash_value <= h;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(int idx, logic [31:0] v);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= 5'(idx * 4);
      pwdata <= v;
      @(negedge clock);
      penable <= 1;
      @(negedge clock);
      psel <= 0;
      penable <= 0;
   endtask

   // Drain results, then let a trailing load finish before touching registers.
   task automatic drain();
      push <= 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // Pick a hash that a walk of some bucket actually reaches, most of the time.
   function automatic logic [26:0] reach_hash();
      longint unsigned s;
      logic [8:0] b;
      b = 9'($urandom_range(511));
      void'(i_chk.walk({b, 18'h3FFFF}, $urandom_range(1, 3), s));
      if (s < 64'h800_0000) return s[26:0];
      return 27'($urandom);
   endfunction

   task automatic random_items(int budget);
      int n, r;
      logic [15:0] a;
      logic [31:0] d;
      n = 0;
      while (n < budget) begin
         r = $urandom_range(99);
         d = $urandom;
         if (r < 45) begin
            if ($urandom_range(9) < 7) send(FN_LOOKUP, 16'($urandom), d, reach_hash());
            else send(FN_LOOKUP, 16'($urandom), d, 27'($urandom));
            n++;
         end else if (r < 70) begin
            a = ($urandom_range(9) < 7) ? 16'($urandom_range(19)) : 16'($urandom);
            send(FN_WORD, a, d, 27'($urandom));
            n++;
         end else if (r < 92) begin
            // keep bucket bounds inside the preloaded table region
            if ($urandom_range(99) < 85) begin
               a = 16'($urandom_range(512));
               d[15:0] = 16'($urandom_range(15));
            end else
               a = 16'($urandom_range(65535, 513));
            send(FN_BUCKET, a, d, 27'($urandom));
            n++;
         end else
            send(FN_NONE, 16'($urandom), d, 27'($urandom));
      end
   endtask

   task automatic load_config(logic [4:0] w, logic [30:0] sl, logic [30:0] ll,
                              logic [30:0] lb, logic [30:0] ls);
      csr_write(REG_CODE_WIDTH, {27'($urandom), w});
      csr_write(REG_SHORT_LIMIT, {1'($urandom), sl});
      csr_write(REG_LONG_LIMIT, {1'($urandom), ll});
      csr_write(REG_LONG_BASE, {1'($urandom), lb});
      csr_write(REG_LONG_STEP, {1'($urandom), ls});
   endtask

   initial begin
      reset = 1;
      push = 0;
      req_func = FN_NONE;
      req_addr = '0;
      req_data = '0;
      req_hash_value = '0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      tx_idle = 8;
      rx_idle = 76;
      hold_req = 0;
      quiet = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // preload every bucket bound and the table region they point into
      for (int b = 0; b < 513; b++) send(FN_BUCKET, 16'(b), {16'($urandom),
                                         16'($urandom_range(15))}, '0);
      for (int a = 0; a < 20; a++) send(FN_WORD, 16'(a), $urandom, '0);

      // directed: ignored writes, unused function, field extremes
      send(FN_BUCKET, 16'hFFFF, 32'hFFFF_FFFF, 27'h7FF_FFFF);
      send(FN_BUCKET, 16'd513, 32'hFFFF_FFFF, '0);
      send(FN_WORD, 16'hFFFF, 32'hFFFF_FFFF, '0);
      send(FN_WORD, 16'h8000, 32'h0, '0);
      send(FN_NONE, 16'hFFFF, 32'hFFFF_FFFF, 27'h7FF_FFFF);
      send(FN_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 27'h0);
      send(FN_LOOKUP, 16'h0, 32'h0, 27'h7FF_FFFF);
      send(FN_LOOKUP, '0, '0, 27'h004_0000);
      for (int i = 0; i < 6; i++) send(FN_LOOKUP, '0, '0, reach_hash());
      random_items(150);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: load_config(5'd31, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                           31'h7FFF_FFFF);
            1: load_config(5'd0, 31'h4000_0000, 31'h2000_0000, 31'd5, 31'd3);
            2: load_config(5'd12, 31'h1000_0000, 31'h6000_0000, 31'd1000, 31'd500);
            3: load_config(5'd3, 31'h3000_0000, 31'h7000_0000, 31'd2, 31'd1);
            default: load_config(5'd20, 31'h0000_1000, 31'h5000_0000, 31'd0,
                                 31'h0000_1000);
         endcase
         if (ph == 2) begin
            tx_idle = 76;
            rx_idle = 8;
         end else if (ph == 4) begin
            tx_idle = 0;
            rx_idle = 0;
            hold_req = 1;
         end
         random_items(ph == 3 ? 100 : 230);
         drain();
      end

      repeat (50) @(negedge clock);
      if (fail_count == 0 && pending == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end
endmodule
